### hdl/bdalu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdalu_pkg: shared types for the binary/decimal add-subtract unit
// Holds the operation codes and the packed operation and result records that
// travel between the pipeline registers and the arithmetic core.
// ----------------------------------------------------------------------------
package bdalu_pkg;

    // Operation kind codes.
    typedef enum logic {
        KIND_ADC = 1'b0,
        KIND_SBC = 1'b1
    } kind_t;

    // Largest valid BCD digit and the nibble correction amount.
    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_ADJUST    = 4'd6;

    // One operation as captured at the input register.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] accumulator;
        logic [7:0] operand;
        logic       carry_in;
        logic       decimal_mode;
    } op_t;

    // One result with its flags.
    typedef struct packed {
        logic [7:0] result;
        logic       carry_out;
        logic       overflow_out;
        logic       negative_out;
        logic       zero_out;
    } res_t;

endpackage
`default_nettype wire

### hdl/bdalu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdalu_core: add-with-carry / subtract-with-borrow datapath
// Combinational binary and packed-BCD arithmetic with the classic flag rules:
// decimal add takes zero from the binary sum and negative/overflow from the
// upper digit before correction; decimal subtract takes all flags from the
// binary difference.
// ----------------------------------------------------------------------------
module bdalu_core
    import bdalu_pkg::*;
(
    input  op_t  op,
    output res_t res
);

    logic [7:0] a;
    logic [7:0] b;
    logic       borrow;

    // Binary sum and difference, one guard bit each.
    logic [8:0] sum;
    logic [8:0] diff;

    // Decimal add digits.
    logic [4:0] add_lo;
    logic [5:0] add_lo_adj;
    logic [4:0] add_hi;
    logic [5:0] add_hi_adj;

    // Decimal subtract digits, five-bit two's complement.
    logic [4:0] sub_lo;
    logic [4:0] sub_lo_adj;
    logic [4:0] sub_hi;
    logic [4:0] sub_hi_adj;

    assign a      = op.accumulator;
    assign b      = op.operand;
    assign borrow = ~op.carry_in;

    // Binary arithmetic shared by both modes.
    assign sum  = {1'b0, a} + {1'b0, b} + {8'd0, op.carry_in};
    assign diff = {1'b0, a} - {1'b0, b} - {8'd0, borrow};

    // Decimal add: correct the low digit, ripple its carry, then the high digit.
    assign add_lo     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, op.carry_in};
    assign add_lo_adj = (add_lo > {1'b0, BCD_MAX_DIGIT})
                        ? ({1'b0, add_lo} + {2'd0, BCD_ADJUST}) : {1'b0, add_lo};
    assign add_hi     = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'd0, add_lo_adj[5] | add_lo_adj[4]};
    assign add_hi_adj = (add_hi > {1'b0, BCD_MAX_DIGIT})
                        ? ({1'b0, add_hi} + {2'd0, BCD_ADJUST}) : {1'b0, add_hi};

    // Decimal subtract: a negative low digit is corrected and borrows from the high one.
    assign sub_lo     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, borrow};
    assign sub_hi     = {1'b0, a[7:4]} - {1'b0, b[7:4]} - {4'd0, sub_lo[4]};
    assign sub_lo_adj = sub_lo[4] ? (sub_lo - {1'b0, BCD_ADJUST}) : sub_lo;
    assign sub_hi_adj = sub_hi[4] ? (sub_hi - {1'b0, BCD_ADJUST}) : sub_hi;

    // Select the result and flags for the operation and mode.
    always_comb
    begin
        res = '0;
        case (op.kind)
            KIND_ADC:
            begin
                res.zero_out = (sum[7:0] == 8'd0);
                if (op.decimal_mode)
                begin
                    res.result       = {add_hi_adj[3:0], add_lo_adj[3:0]};
                    res.carry_out    = |add_hi_adj[5:4];
                    res.negative_out = add_hi[3];
                    res.overflow_out = (add_hi[3] ^ a[7]) & ~(a[7] ^ b[7]);
                end
                else
                begin
                    res.result       = sum[7:0];
                    res.carry_out    = sum[8];
                    res.negative_out = sum[7];
                    res.overflow_out = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
                end
            end
            KIND_SBC:
            begin
                res.carry_out    = ~diff[8];
                res.negative_out = diff[7];
                res.zero_out     = (diff[7:0] == 8'd0);
                res.overflow_out = (a[7] ^ diff[7]) & (a[7] ^ b[7]);
                res.result       = op.decimal_mode ? {sub_hi_adj[3:0], sub_lo_adj[3:0]}
                                                   : diff[7:0];
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/binary_decimal_add_subtract_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_decimal_add_subtract_alu: 8-bit binary/BCD add and subtract unit
// Input register, combinational arithmetic core and result register.
// ----------------------------------------------------------------------------
// The unit accepts one operation per clock unless the result side holds it back,
// and passes each operation through the input register and then the result
// register. Both registers advance whenever the stage after them is empty or
// being drained, so with out_ready held high the throughput is one transfer
// per cycle; the short path through the arithmetic core sets the clock limit.
module binary_decimal_add_subtract_alu
    import bdalu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] accumulator,
    input  wire logic [7:0] operand,
    input  wire logic       carry_in,
    input  wire logic       decimal_mode,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      result,
    output logic            carry_out,
    output logic            overflow_out,
    output logic            negative_out,
    output logic            zero_out
);

    op_t  op_reg;
    logic op_valid_reg;
    res_t res_reg;
    logic res_valid_reg;
    res_t res_next;
    logic res_ready;

    // Each stage takes a new transfer when it is empty or being emptied.
    assign res_ready = ~res_valid_reg | out_ready;
    assign in_ready  = ~op_valid_reg | res_ready;

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            op_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg.kind         <= kind_t'(kind);
            op_reg.accumulator  <= accumulator;
            op_reg.operand      <= operand;
            op_reg.carry_in     <= carry_in;
            op_reg.decimal_mode <= decimal_mode;
        end
    end

    // Arithmetic core.
    bdalu_core u_core
    (
        .op  (op_reg),
        .res (res_next)
    );

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            res_valid_reg <= op_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (op_valid_reg && res_ready)
        begin
            res_reg <= res_next;
        end
    end

    // Output ports.
    assign out_valid    = res_valid_reg;
    assign result       = res_reg.result;
    assign carry_out    = res_reg.carry_out;
    assign overflow_out = res_reg.overflow_out;
    assign negative_out = res_reg.negative_out;
    assign zero_out     = res_reg.zero_out;

endmodule
`default_nettype wire

### bench/binary_decimal_add_subtract_alu_test.sv
// ----------------------------------------------------------------------------
// binary_decimal_add_subtract_alu_test: self-checking bench for the ALU
// Sends directed corner cases and then random add and subtract operations in
// both binary and decimal mode. Both sides idle and stall at random. A
// scoreboard predicts each result from the accepted operation and compares
// every returned field in order.
// ----------------------------------------------------------------------------
module binary_decimal_add_subtract_alu_test;
    import bdalu_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned HANG_LIMIT   = 2000;
    localparam int unsigned RANDOM_OPS   = 700;
    localparam int unsigned MAX_IDLE     = 13;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Predicts each result and keeps the ones still owed by the unit.
    class alu_scoreboard;
        res_t        results_due[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Add with carry or subtract with borrow, binary or packed BCD.
        function res_t adc_sbc(op_t op);
            res_t        r;
            logic [7:0]  a;
            logic [7:0]  b;
            logic        borrow;
            logic [8:0]  sum;
            logic [15:0] diff;
            logic [5:0]  lo_sum;
            logic [5:0]  hi_sum;
            logic [15:0] lo_diff;
            logic [15:0] hi_diff;
            a      = op.accumulator;
            b      = op.operand;
            borrow = ~op.carry_in;
            sum    = {1'b0, a} + {1'b0, b} + {8'd0, op.carry_in};
            diff   = {8'd0, a} - {8'd0, b} - {15'd0, borrow};
            if (op.kind == KIND_ADC)
            begin
                // Decimal add still takes its zero flag from the binary sum.
                r.zero_out = (sum[7:0] == 8'h00);
                if (!op.decimal_mode)
                begin
                    r.result       = sum[7:0];
                    r.carry_out    = sum[8];
                    r.overflow_out = (a[7] == b[7]) && (sum[7] != a[7]);
                    r.negative_out = sum[7];
                end
                else
                begin
                    lo_sum = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, op.carry_in};
                    if (lo_sum > {2'b00, BCD_MAX_DIGIT})
                        lo_sum = lo_sum + {2'b00, BCD_ADJUST};
                    hi_sum = {2'b00, a[7:4]} + {2'b00, b[7:4]};
                    if (lo_sum > 6'd15)
                        hi_sum = hi_sum + 6'd1;
                    // Sign and overflow are taken before the upper digit is corrected.
                    r.negative_out = hi_sum[3];
                    r.overflow_out = (hi_sum[3] != a[7]) && (a[7] == b[7]);
                    if (hi_sum > {2'b00, BCD_MAX_DIGIT})
                        hi_sum = hi_sum + {2'b00, BCD_ADJUST};
                    r.carry_out = (hi_sum > 6'd15);
                    r.result    = {hi_sum[3:0], lo_sum[3:0]};
                end
            end
            else
            begin
                // Subtract flags come from the binary difference in both modes.
                r.carry_out    = (diff[15:8] == 8'h00);
                r.overflow_out = (a[7] != diff[7]) && (a[7] != b[7]);
                r.negative_out = diff[7];
                r.zero_out     = (diff[7:0] == 8'h00);
                if (!op.decimal_mode)
                begin
                    r.result = diff[7:0];
                end
                else
                begin
                    lo_diff = {12'd0, a[3:0]} - {12'd0, b[3:0]} - {15'd0, borrow};
                    hi_diff = {12'd0, a[7:4]} - {12'd0, b[7:4]};
                    if (lo_diff[4])
                    begin
                        lo_diff = lo_diff - {12'd0, BCD_ADJUST};
                        hi_diff = hi_diff - 16'd1;
                    end
                    if (hi_diff[4])
                        hi_diff = hi_diff - {12'd0, BCD_ADJUST};
                    r.result = {hi_diff[3:0], lo_diff[3:0]};
                end
            end
            return r;
        endfunction

        function void note_op(op_t op);
            results_due.push_back(adc_sbc(op));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one returned result with the oldest prediction.
        function void check_result(res_t got);
            res_t want;
            if (results_due.size() == 0)
            begin
                $error("result 0x%02h arrived with no operation outstanding", got.result);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            compare_field("result", 32'(want.result), 32'(got.result));
            compare_field("carry_out", 32'(want.carry_out), 32'(got.carry_out));
            compare_field("overflow_out", 32'(want.overflow_out), 32'(got.overflow_out));
            compare_field("negative_out", 32'(want.negative_out), 32'(got.negative_out));
            compare_field("zero_out", 32'(want.zero_out), 32'(got.zero_out));
        endfunction

        function int unsigned outstanding();
            return results_due.size();
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       kind         = 1'b0;
    logic [7:0] accumulator  = 8'h00;
    logic [7:0] operand      = 8'h00;
    logic       carry_in     = 1'b0;
    logic       decimal_mode = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] result;
    logic       carry_out;
    logic       overflow_out;
    logic       negative_out;
    logic       zero_out;

    alu_scoreboard sb = new();

    // Idling phases: each side either idles at random or runs flat out.
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int unsigned phase_left   = 0;

    binary_decimal_add_subtract_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .accumulator  (accumulator),
        .operand      (operand),
        .carry_in     (carry_in),
        .decimal_mode (decimal_mode),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result),
        .carry_out    (carry_out),
        .overflow_out (overflow_out),
        .negative_out (negative_out),
        .zero_out     (zero_out)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Presents one operation after a random gap and waits for its transfer.
    task automatic issue_op(input kind_t k, input logic [7:0] a, input logic [7:0] b,
                            input logic c, input logic dec);
        int unsigned gap;
        if (phase_left == 0)
        begin
            phase_left   = $urandom_range(20, 80);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
        end
        phase_left--;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        accumulator  <= a;
        operand      <= b;
        carry_in     <= c;
        decimal_mode <= dec;
        do @(posedge clk); while (!in_ready);
    endtask

    // Holds off new operations until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Mostly valid BCD digits, some arbitrary bytes and some boundary values.
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[8];
        edges = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h99, 8'h9a, 8'h0f, 8'hf0};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            6, 7, 8:          return 8'($urandom_range(0, 255));
            default:          return edges[$urandom_range(0, 7)];
        endcase
    endfunction

    // Result side: random back-pressure, one transfer per loop.
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Records accepted operations and checks returned results.
    always @(posedge clk)
    begin
        op_t  op;
        res_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                op.kind         = kind_t'(kind);
                op.accumulator  = accumulator;
                op.operand      = operand;
                op.carry_in     = carry_in;
                op.decimal_mode = decimal_mode;
                sb.note_op(op);
            end
            if (out_valid && out_ready)
            begin
                got.result       = result;
                got.carry_out    = carry_out;
                got.overflow_out = overflow_out;
                got.negative_out = negative_out;
                got.zero_out     = zero_out;
                sb.check_result(got);
            end
        end
    end

    // Hang detection: too long without a transfer on either side.
    always @(posedge clk)
    begin
        int unsigned quiet_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Reset, directed corner cases, random operations, then the verdict.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Binary add: zero, all ones, signed overflow, carry with zero.
        issue_op(KIND_ADC, 8'h00, 8'h00, 1'b0, 1'b0);
        issue_op(KIND_ADC, 8'hff, 8'hff, 1'b1, 1'b0);
        issue_op(KIND_ADC, 8'h7f, 8'h01, 1'b0, 1'b0);
        issue_op(KIND_ADC, 8'h80, 8'h80, 1'b0, 1'b0);
        issue_op(KIND_ADC, 8'hff, 8'h00, 1'b1, 1'b0);
        // Binary subtract: zero, borrow out, signed overflow, borrow in.
        issue_op(KIND_SBC, 8'h00, 8'h00, 1'b1, 1'b0);
        issue_op(KIND_SBC, 8'h00, 8'h01, 1'b1, 1'b0);
        issue_op(KIND_SBC, 8'h80, 8'h01, 1'b1, 1'b0);
        issue_op(KIND_SBC, 8'h7f, 8'hff, 1'b0, 1'b0);
        issue_op(KIND_SBC, 8'hff, 8'hff, 1'b0, 1'b0);
        // Decimal add: digit carry, wrap to zero with a nonzero binary sum,
        // sign and overflow from the uncorrected upper digit, invalid digits.
        issue_op(KIND_ADC, 8'h09, 8'h01, 1'b0, 1'b1);
        issue_op(KIND_ADC, 8'h99, 8'h01, 1'b0, 1'b1);
        issue_op(KIND_ADC, 8'h50, 8'h50, 1'b0, 1'b1);
        issue_op(KIND_ADC, 8'h79, 8'h00, 1'b1, 1'b1);
        issue_op(KIND_ADC, 8'h99, 8'h99, 1'b1, 1'b1);
        issue_op(KIND_ADC, 8'hff, 8'hff, 1'b1, 1'b1);
        issue_op(KIND_ADC, 8'h80, 8'h80, 1'b0, 1'b1);
        issue_op(KIND_ADC, 8'h0a, 8'h06, 1'b0, 1'b1);
        // Decimal subtract: wrap below zero, digit borrow, invalid digits.
        issue_op(KIND_SBC, 8'h00, 8'h01, 1'b1, 1'b1);
        issue_op(KIND_SBC, 8'h00, 8'h00, 1'b0, 1'b1);
        issue_op(KIND_SBC, 8'h10, 8'h01, 1'b1, 1'b1);
        issue_op(KIND_SBC, 8'h99, 8'h99, 1'b1, 1'b1);
        issue_op(KIND_SBC, 8'h0f, 8'hf0, 1'b1, 1'b1);
        issue_op(KIND_SBC, 8'hff, 8'haa, 1'b0, 1'b1);
        issue_op(KIND_SBC, 8'h80, 8'h01, 1'b1, 1'b1);

        // Random operations, with a full drain now and then.
        for (int unsigned i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 233 == 0)
                drain_results();
            issue_op(kind_t'($urandom_range(0, 1)), pick_byte(), pick_byte(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
